// ----- sv/tgarle_pkg.sv -----
// Shared types and constants for the Targa RLE pixel decoder.
`timescale 1ns / 1ps
`default_nettype none

package tgarle_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_MODE    = 1'd1;

  localparam logic [CFG_DATA_W-1:0] PIXEL_BYTES_RST = 3'd3;

  // Pixel format, coded as bytes per pixel minus one
  localparam logic [1:0] PIX_GRAY   = 2'd0;
  localparam logic [1:0] PIX_RGB555 = 2'd1;
  localparam logic [1:0] PIX_BGR    = 2'd2;
  localparam logic [1:0] PIX_BGRA   = 2'd3;

  localparam logic [7:0] HDR_REPEAT_BIT = 8'h80;
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1
  } phase_t;

  // Pixel handed from the parser to the converter
  typedef struct packed {
    logic        done;
    logic [1:0]  fmt;
    logic [23:0] bytes;
    logic [7:0]  run;
  } pix_t;

endpackage

`default_nettype wire

// ----- sv/tga_rle_pixel_decoder.sv -----
// A byte is held in the input register, a finished pixel in the result register.
// Throughput: one byte per cycle unless out_stall holds a full result stage; a
// pixel appears on the byte that completes it. Header bytes and non-final pixel
// bytes yield no item. The parser state register sets the rate: it updates once
// per byte. Reset (rst_n low, synchronous) empties both stages, rewinds the
// parser and loads pixel_bytes = 3, rle_mode = 0.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder
  import tgarle_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     in_data_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [BYTE_W-1:0]          out_red,
  output logic [BYTE_W-1:0]          out_green,
  output logic [BYTE_W-1:0]          out_blue,
  output logic [BYTE_W-1:0]          out_run_length,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] pixel_bytes_r;
  logic                  rle_mode_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] red_r, green_r, blue_r, run_r;

  logic              out_free;
  logic              fire;
  pix_t              pix;
  logic [BYTE_W-1:0] conv_red, conv_green, conv_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_bytes_r <= PIXEL_BYTES_RST;
      rle_mode_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIXEL_BYTES: pixel_bytes_r <= cfg_data;
        REG_RLE_MODE:    rle_mode_r    <= cfg_data[0];
        default:         pixel_bytes_r <= pixel_bytes_r;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  // Input stage: take a byte whenever the held one moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_data_byte;
    end
  end

  tgarle_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (s1_byte_r),
    .pixel_bytes (pixel_bytes_r),
    .rle_mode    (rle_mode_r),
    .pix         (pix)
  );

  tgarle_convert u_convert (
    .pix   (pix),
    .red   (conv_red),
    .green (conv_green),
    .blue  (conv_blue)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = fire && pix.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pix.done) begin
      red_r   <= conv_red;
      green_r <= conv_green;
      blue_r  <= conv_blue;
      run_r   <= pix.run;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_run_length = run_r;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result stage not empty after reset");

  a_pixel_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire && pix.done |=> out_valid_r)
    else $error("completed pixel lost");

  a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_byte_r))
    else $error("blocked byte dropped");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> run_r != '0)
    else $error("zero run length");
`endif

endmodule

`default_nettype wire

// ----- sv/tgarle_parser.sv -----
// Packet parser and pixel byte gathering for the Targa RLE pixel decoder.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_parser
  import tgarle_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire logic [BYTE_W-1:0]     data_byte,
  input  wire logic [CFG_DATA_W-1:0] pixel_bytes,
  input  wire logic                  rle_mode,
  output pix_t                       pix
);

  phase_t      phase_r, phase_nxt;
  logic        repeat_r, repeat_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [1:0]  bpos_r, bpos_nxt;
  logic [23:0] asm_r, asm_nxt;

  logic [1:0]  fmt;
  logic [23:0] gathered;
  logic        last_byte;
  logic        is_header;
  logic [7:0]  remain_dec;

  // Zero counts as one byte, anything above four as four
  always_comb begin
    if (pixel_bytes == '0) begin
      fmt = PIX_GRAY;
    end else if (pixel_bytes > 3'd4) begin
      fmt = PIX_BGRA;
    end else begin
      fmt = 2'(pixel_bytes - 3'd1);
    end
  end

  always_comb begin
    gathered = asm_r;
    case (bpos_r)
      2'd0:    gathered[7:0]   = data_byte;
      2'd1:    gathered[15:8]  = data_byte;
      2'd2:    gathered[23:16] = data_byte;
      default: gathered = asm_r;
    endcase
  end

  assign last_byte  = (bpos_r >= fmt);
  assign is_header  = rle_mode && (phase_r == PH_HEADER);
  assign remain_dec = (remain_r != '0) ? remain_r - 8'd1 : remain_r;

  // Next packet phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire && rle_mode) begin
      unique case (phase_r)
        PH_HEADER: phase_nxt = PH_DATA;
        PH_DATA: begin
          if (last_byte && (repeat_r || remain_dec == '0)) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  // Counters, assembly and the pixel handed on
  always_comb begin
    repeat_nxt = repeat_r;
    remain_nxt = remain_r;
    bpos_nxt   = bpos_r;
    asm_nxt    = asm_r;
    pix.done   = 1'b0;
    pix.fmt    = fmt;
    pix.bytes  = gathered;
    pix.run    = 8'd1;
    if (is_header) begin
      repeat_nxt = |(data_byte & HDR_REPEAT_BIT);
      remain_nxt = (data_byte & HDR_COUNT_MASK) + 8'd1;
      bpos_nxt   = '0;
    end else begin
      asm_nxt  = gathered;
      bpos_nxt = last_byte ? 2'd0 : bpos_r + 2'd1;
      pix.done = last_byte;
      if (rle_mode && last_byte) begin
        if (repeat_r) begin
          pix.run    = (remain_r == '0) ? 8'd1 : remain_r;
          remain_nxt = '0;
        end else begin
          remain_nxt = remain_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      repeat_r <= 1'b0;
      remain_r <= '0;
      bpos_r   <= '0;
      asm_r    <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      repeat_r <= repeat_nxt;
      remain_r <= remain_nxt;
      bpos_r   <= bpos_nxt;
      asm_r    <= asm_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tgarle_convert.sv -----
// Pixel format conversion to 8-bit RGB for the Targa RLE pixel decoder.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_convert
  import tgarle_pkg::*;
(
  input  pix_t                   pix,
  output logic [BYTE_W-1:0]      red,
  output logic [BYTE_W-1:0]      green,
  output logic [BYTE_W-1:0]      blue
);

  logic [15:0] v555;

  assign v555 = pix.bytes[15:0];

  always_comb begin
    unique case (pix.fmt) inside
      PIX_GRAY: begin
        red   = pix.bytes[7:0];
        green = pix.bytes[7:0];
        blue  = pix.bytes[7:0];
      end
      PIX_RGB555: begin
        // widen each 5-bit field, top bit ignored
        red   = {v555[14:10], 3'b000};
        green = {v555[9:5], 3'b000};
        blue  = {v555[4:0], 3'b000};
      end
      PIX_BGR, PIX_BGRA: begin
        red   = pix.bytes[23:16];
        green = pix.bytes[15:8];
        blue  = pix.bytes[7:0];
      end
      default: begin
        red   = pix.bytes[23:16];
        green = pix.bytes[15:8];
        blue  = pix.bytes[7:0];
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- test/tga_rle_pixel_decoder_tb.sv -----
// Self-checking bench for the Targa pixel-data decoder: byte driver, pixel monitor, predictor.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;
  import tgarle_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BYTES   = 75;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] run;
  } pixel_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_data_byte   = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [BYTE_W-1:0]     out_red;
  logic [BYTE_W-1:0]     out_green;
  logic [BYTE_W-1:0]     out_blue;
  logic [BYTE_W-1:0]     out_run_length;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  tga_rle_pixel_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_run_length (out_run_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  logic [7:0] bytes_to_send[$];
  pixel_t     pixels_due[$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  bit         in_taken    = 1'b0;
  int         hold_asked  = 0;

  // Register copies and decoder state held by the predictor
  logic [2:0]  reg_pix_bytes = PIXEL_BYTES_RST;
  logic        reg_rle       = 1'b0;
  phase_t      pkt_phase     = PH_HEADER;
  logic        pkt_repeat    = 1'b0;
  logic [7:0]  pkt_left      = '0;
  logic [1:0]  byte_pos      = '0;
  logic [23:0] pix_acc       = '0;

  function automatic logic [1:0] pixel_format(input logic [2:0] nbytes);
    if (nbytes == 3'd0) return PIX_GRAY;
    if (nbytes > 3'd4) return PIX_BGRA;
    return 2'(nbytes - 3'd1);
  endfunction

  function automatic pixel_t convert(input logic [1:0] fmt, input logic [23:0] acc,
                                     input logic [7:0] run);
    pixel_t     p;
    logic [15:0] v;
    v = acc[15:0];
    case (fmt)
      PIX_GRAY:   p = '{acc[7:0], acc[7:0], acc[7:0], run};
      PIX_RGB555: p = '{{v[14:10], 3'b000}, {v[9:5], 3'b000}, {v[4:0], 3'b000}, run};
      default:    p = '{acc[23:16], acc[15:8], acc[7:0], run};
    endcase
    return p;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [1:0] fmt;
    logic       done;
    fmt = pixel_format(reg_pix_bytes);
    if (reg_rle && pkt_phase == PH_HEADER) begin
      pkt_repeat = b[7];
      pkt_left   = {1'b0, b[6:0]} + 8'd1;
      byte_pos   = 2'd0;
      pkt_phase  = PH_DATA;
    end else begin
      // alpha byte is not stored
      if (byte_pos != 2'd3) pix_acc[byte_pos*8 +: 8] = b;
      done     = (byte_pos >= fmt);
      byte_pos = done ? 2'd0 : byte_pos + 2'd1;
      if (done) begin
        if (!reg_rle) begin
          pixels_due.push_back(convert(fmt, pix_acc, 8'd1));
        end else if (pkt_repeat) begin
          pixels_due.push_back(convert(fmt, pix_acc, (pkt_left == 8'd0) ? 8'd1 : pkt_left));
          pkt_left  = 8'd0;
          pkt_phase = PH_HEADER;
        end else begin
          pixels_due.push_back(convert(fmt, pix_acc, 8'd1));
          if (pkt_left != 8'd0) pkt_left = pkt_left - 8'd1;
          if (pkt_left == 8'd0) pkt_phase = PH_HEADER;
        end
      end
    end
  endtask

  task automatic check_pixel();
    pixel_t got;
    pixel_t want;
    got = '{out_red, out_green, out_blue, out_run_length};
    if (pixels_due.size() == 0) begin
      mismatches++;
      $display("%0t: pixel with none expected: r=%h g=%h b=%h run=%0d",
               $time, got.red, got.green, got.blue, got.run);
    end else begin
      want = pixels_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (got.red !== want.red)
          $display("%0t: red expected %h actual %h", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green expected %h actual %h", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
        if (got.run !== want.run)
          $display("%0t: run_length expected %0d actual %0d", $time, want.run, got.run);
      end
    end
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Sample both channels
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) decode_byte(in_data_byte);
    if (rst_n && out_valid && !out_stall) check_pixel();
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[tga_rle_pixel_decoder] ERROR");
      $finish;
    end
  end

  // Byte driver: hold a stalled item, else idle or offer the next one
  int tx_gap  = 0;
  int tx_calm = 0;
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (bytes_to_send.size() > 0) begin
        in_valid     <= 1'b1;
        in_data_byte <= bytes_to_send.pop_front();
        if (tx_calm > 0) begin
          tx_calm--;
        end else begin
          if ($urandom_range(0, 29) == 0) tx_calm = $urandom_range(20, 80);
          tx_gap = idle_len();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Pixel receiver stall, with an occasional long hold-off on request
  int rx_hold = 0;
  int rx_free = 0;
  int rx_busy = 0;
  int holds_done = 0;
  always @(negedge clk) begin
    logic stall_nxt;
    if (holds_done != hold_asked) begin
      holds_done = hold_asked;
      rx_hold    = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      stall_nxt = 1'b1;
    end else if (rx_free > 0) begin
      rx_free--;
      stall_nxt = 1'b0;
    end else if (rx_busy > 0) begin
      rx_busy--;
      stall_nxt = 1'b1;
    end else begin
      rx_free   = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 100) : $urandom_range(0, 6);
      rx_busy   = idle_len();
      stall_nxt = 1'b0;
    end
    out_stall <= stall_nxt;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_PIXEL_BYTES) reg_pix_bytes = val;
    else reg_rle = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input logic [2:0] pix, input logic rle);
    write_reg(REG_PIXEL_BYTES, pix);
    write_reg(REG_RLE_MODE, {2'b00, rle});
  endtask

  // Wait until every byte is in and every pixel out, then let the pipe empty
  task automatic settle();
    while (bytes_to_send.size() != 0 || in_valid || pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic fill_random(input int target);
    int   n;
    int   size;
    int   cnt;
    int   npix;
    logic rep;
    size = int'(pixel_format(reg_pix_bytes)) + 1;
    n = 0;
    while (n < target) begin
      if (!reg_rle) begin
        bytes_to_send.push_back(8'($urandom));
        n++;
      end else begin
        rep = 1'($urandom_range(0, 1));
        if (rep) cnt = ($urandom_range(0, 4) == 0) ? 127 : $urandom_range(0, 127);
        else cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
        bytes_to_send.push_back({rep, 7'(cnt)});
        npix = rep ? 1 : cnt + 1;
        repeat (npix * size) bytes_to_send.push_back(8'($urandom));
        n += 1 + npix * size;
      end
    end
    // leave a packet cut short now and then
    if (reg_rle && $urandom_range(0, 2) == 0) begin
      bytes_to_send.push_back(8'($urandom));
      repeat ($urandom_range(0, size)) bytes_to_send.push_back(8'($urandom));
    end
  endtask

  initial begin
    logic [2:0] pix;
    logic       rle;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: three-byte BGR, uncompressed
    bytes_to_send.push_back(8'hff); bytes_to_send.push_back(8'h00);
    bytes_to_send.push_back(8'h80);
    settle();

    set_mode(3'd1, 1'b0);
    bytes_to_send.push_back(8'h00); bytes_to_send.push_back(8'hff);
    settle();

    // 5-5-5: all fields full, then only the ignored top bit
    set_mode(3'd2, 1'b0);
    bytes_to_send.push_back(8'hff); bytes_to_send.push_back(8'h7f);
    bytes_to_send.push_back(8'h00); bytes_to_send.push_back(8'h80);
    settle();

    set_mode(3'd4, 1'b0);
    bytes_to_send.push_back(8'h11); bytes_to_send.push_back(8'h22);
    bytes_to_send.push_back(8'h33); bytes_to_send.push_back(8'h44);
    settle();

    // Zero size acts as one byte: longest repeat, shortest raw, shortest repeat
    set_mode(3'd0, 1'b1);
    bytes_to_send.push_back(8'hff); bytes_to_send.push_back(8'haa);
    bytes_to_send.push_back(8'h00); bytes_to_send.push_back(8'h55);
    bytes_to_send.push_back(8'h80); bytes_to_send.push_back(8'h01);
    settle();

    // Oversize acts as four bytes
    set_mode(3'd7, 1'b1);
    bytes_to_send.push_back(8'h81); bytes_to_send.push_back(8'hc3);
    bytes_to_send.push_back(8'h3c); bytes_to_send.push_back(8'h5a);
    bytes_to_send.push_back(8'ha5);
    settle();

    // Size change with a pixel half gathered
    set_mode(3'd3, 1'b0);
    bytes_to_send.push_back(8'he7); bytes_to_send.push_back(8'h18);
    settle();
    write_reg(REG_PIXEL_BYTES, 3'd2);
    bytes_to_send.push_back(8'h99);
    settle();

    for (int i = 0; i < RANDOM_PHASES; i++) begin
      if (i == 2) begin
        pix = 3'd1;
        rle = 1'b0;
      end else begin
        pix = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        rle = ($urandom_range(0, 3) != 0);
      end
      set_mode(pix, rle);
      if (i == 2) hold_asked++;
      fill_random(PHASE_BYTES);
      settle();
    end

    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("[tga_rle_pixel_decoder] OK");
    end else begin
      $display("[tga_rle_pixel_decoder] ERROR");
    end
    $finish;
  end

endmodule
